// File: rtl/core/mqpf_pkg.sv
// Shared constants, codes and types for the multi-queue packet FIFO.
// No dependencies; every other file of the block imports this package.
package mqpf_pkg;

   localparam int NUM_QUEUES    = 16;
   localparam int QUEUE_DEPTH   = 16;
   localparam int PAYLOAD_BYTES = 8;

   localparam int QW    = $clog2(NUM_QUEUES);
   localparam int PW    = $clog2(QUEUE_DEPTH);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int AW    = $clog2(NUM_QUEUES * QUEUE_DEPTH);
   localparam int OCC_W = 5;

   localparam logic [1:0] REQ_ENQ   = 2'd0;
   localparam logic [1:0] REQ_DEQ   = 2'd1;
   localparam logic [1:0] REQ_SIZE  = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [CW-1:0] count;
      logic [PW-1:0] head;
      logic [PW-1:0] tail;
   } ptr_entry_type;

   typedef struct packed {
      logic [7:0]  dest;
      logic [7:0]  src;
      logic [63:0] payload;
   } packet_type;

endpackage

// File: rtl/core/mqpf_ptr_table.sv
// Per-queue head, tail and count table: one synchronous memory, registered read.
// Valid bits per queue make a never-written or reset queue read as empty.
// Depends on mqpf_pkg.
module mqpf_ptr_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic                  wr_en,
   input  logic [mqpf_pkg::QW-1:0] index,
   input  mqpf_pkg::ptr_entry_type wr_data,
   output mqpf_pkg::ptr_entry_type rd_data
);
   import mqpf_pkg::*;

   ptr_entry_type             mem [NUM_QUEUES];
   logic [NUM_QUEUES-1:0]     valid_ff;
   ptr_entry_type             rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[index] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[index] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[index] ? mem[index] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/mqpf_packet_store.sv
// Packet memory holding every ring slot of every queue, registered read.
// Slot address is queue times depth plus ring position. Depends on mqpf_pkg.
module mqpf_packet_store (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic                    wr_en,
   input  logic [mqpf_pkg::QW-1:0] queue,
   input  logic [mqpf_pkg::PW-1:0] slot,
   input  mqpf_pkg::packet_type    wr_data,
   output mqpf_pkg::packet_type    rd_data
);
   import mqpf_pkg::*;

   packet_type        mem [NUM_QUEUES * QUEUE_DEPTH];
   packet_type        rd_data_ff;
   logic [AW-1:0]     addr;

   assign addr = AW'(AW'(queue) * AW'(QUEUE_DEPTH)) + AW'(slot);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/multi_queue_packet_fifo.sv
// Multi-queue packet FIFO: enqueue, dequeue, size query and clear per queue.
// A request reads the pointer table when accepted, reads or writes the packet memory in the
// lookup state and is answered from the access state; busy holds off a new request until then.
// The receiver cannot stall; csr writes are always taken.
// Reset (synchronous): all queues empty, max payload bytes 8, no request in flight.
// Depends on mqpf_pkg, mqpf_ptr_table and mqpf_packet_store.
module multi_queue_packet_fifo (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_queue_index,
   input  logic [7:0]  req_source_address,
   input  logic [7:0]  req_dest_address,
   input  logic [63:0] req_payload_in,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_source_address_out,
   output logic [7:0]  rsp_dest_address_out,
   output logic [63:0] rsp_payload_out,
   output logic [4:0]  rsp_occupancy,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);
   import mqpf_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_ACCESS = 2'd2;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   logic [1:0]        state_ff, state_in;
   logic [3:0]        max_bytes_ff;
   logic [1:0]        req_type_ff;
   logic [QW-1:0]     queue_ff;
   logic              in_range_ff;
   packet_type        pkt_ff;
   logic [1:0]        status_ff;
   logic [OCC_W-1:0]  occ_ff;
   logic              deq_ok_ff;
   logic              strobe_ff;
   logic [1:0]        rsp_status_ff;
   packet_type        rsp_pkt_ff;
   logic [OCC_W-1:0]  rsp_occ_ff;

   logic              accept;
   logic              lookup;
   logic [63:0]       masked_payload;
   ptr_entry_type     ptr_rd, ent_in;
   logic              ptr_wr, pkt_wr, pkt_rd;
   logic              ptr_wr_calc, pkt_wr_calc, pkt_rd_calc;
   logic [PW-1:0]     pkt_slot;
   logic [1:0]        status_calc;
   logic [OCC_W-1:0]  occ_calc;
   packet_type        pkt_rd_data;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign lookup    = (state_ff == S_LOOKUP);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= 4'd8;
      end else if (csr_valid && csr_ready) begin
         max_bytes_ff <= csr_data;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked_payload[i*8 +: 8] = ((i < PAYLOAD_BYTES) && (i < int'(max_bytes_ff))) ?
                                    req_payload_in[i*8 +: 8] : 8'd0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: state_in = S_ACCESS;
         S_ACCESS: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == S_ACCESS);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_type_ff      <= req_type;
         queue_ff         <= QW'(req_queue_index);
         in_range_ff      <= (int'(req_queue_index) < NUM_QUEUES);
         pkt_ff.src       <= req_source_address;
         pkt_ff.dest      <= req_dest_address;
         pkt_ff.payload   <= masked_payload;
      end
   end

   always_comb begin
      ent_in      = ptr_rd;
      ptr_wr_calc = 1'b0;
      pkt_wr_calc = 1'b0;
      pkt_rd_calc = 1'b0;
      pkt_slot    = ptr_rd.tail;
      status_calc = ST_OK;
      if (in_range_ff) begin
         case (req_type_ff)
            REQ_ENQ: begin
               if (ptr_rd.count >= CW'(QUEUE_DEPTH)) begin
                  status_calc = ST_FULL;
               end else begin
                  pkt_wr_calc  = 1'b1;
                  ptr_wr_calc  = 1'b1;
                  ent_in.tail  = ring_next(ptr_rd.tail);
                  ent_in.count = ptr_rd.count + CW'(1);
               end
            end
            REQ_DEQ: begin
               if (ptr_rd.count == '0) begin
                  status_calc = ST_EMPTY;
               end else begin
                  pkt_rd_calc  = 1'b1;
                  ptr_wr_calc  = 1'b1;
                  pkt_slot     = ptr_rd.head;
                  ent_in.head  = ring_next(ptr_rd.head);
                  ent_in.count = ptr_rd.count - CW'(1);
               end
            end
            REQ_CLEAR: begin
               ptr_wr_calc = 1'b1;
               ent_in      = '0;
            end
            default: ;
         endcase
      end
      occ_calc = in_range_ff ? OCC_W'(ent_in.count) : '0;
   end

   assign ptr_wr = lookup && ptr_wr_calc;
   assign pkt_wr = lookup && pkt_wr_calc;
   assign pkt_rd = lookup && pkt_rd_calc;

   always_ff @(posedge clock) begin
      if (lookup) begin
         status_ff <= status_calc;
         occ_ff    <= occ_calc;
         deq_ok_ff <= pkt_rd_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ACCESS) begin
         rsp_status_ff <= status_ff;
         rsp_occ_ff    <= occ_ff;
         rsp_pkt_ff    <= deq_ok_ff ? pkt_rd_data : '0;
      end
   end

   mqpf_ptr_table u_ptr_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .wr_en   (ptr_wr),
      .index   (accept ? QW'(req_queue_index) : queue_ff),
      .wr_data (ent_in),
      .rd_data (ptr_rd)
   );

   mqpf_packet_store u_packet_store (
      .clock   (clock),
      .rd_en   (pkt_rd),
      .wr_en   (pkt_wr),
      .queue   (queue_ff),
      .slot    (pkt_slot),
      .wr_data (pkt_ff),
      .rd_data (pkt_rd_data)
   );

   assign rsp_strobe             = strobe_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_source_address_out = rsp_pkt_ff.src;
   assign rsp_dest_address_out   = rsp_pkt_ff.dest;
   assign rsp_payload_out        = rsp_pkt_ff.payload;
   assign rsp_occupancy          = rsp_occ_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOKUP) ##1 (state_ff == S_ACCESS) ##1 rsp_strobe)
      else $error("request did not complete in three cycles");

   assert property (@(posedge clock) disable iff (reset)
      (ptr_wr || pkt_wr || pkt_rd) |-> $past(accept))
      else $error("memory access outside the lookup cycle");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_EMPTY)) |->
         ((rsp_payload_out == '0) && (rsp_occupancy == '0)))
      else $error("empty dequeue returned data");

   assert property (@(posedge clock) disable iff (reset)
      (pkt_wr && pkt_rd) == 1'b0)
      else $error("packet memory read and written together");
`endif

endmodule

// File: dv/mqpf_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the multi-queue packet FIFO: tracks every queue, predicts each response
// word from the accepted requests and csr writes, and compares it field by field.
// Depends on mqpf_pkg for sizes and request and status codes.
module mqpf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_queue_index,
   input  logic [7:0]  req_source_address,
   input  logic [7:0]  req_dest_address,
   input  logic [63:0] req_payload_in,
   input  logic        rsp_strobe,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_source_address_out,
   input  logic [7:0]  rsp_dest_address_out,
   input  logic [63:0] rsp_payload_out,
   input  logic [4:0]  rsp_occupancy,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_data,
   output int          fail_count,
   output int          replies_pending,
   output int          full_drops,
   output int          empty_reads
);
   import mqpf_pkg::*;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       src;
      logic [7:0]       dst;
      logic [63:0]      payload;
      logic [OCC_W-1:0] occupancy;
   } queue_reply_type;

   logic [7:0]    src_mem  [NUM_QUEUES][QUEUE_DEPTH];
   logic [7:0]    dst_mem  [NUM_QUEUES][QUEUE_DEPTH];
   logic [63:0]   pay_mem  [NUM_QUEUES][QUEUE_DEPTH];
   logic [PW-1:0] head_ptr [NUM_QUEUES];
   logic [PW-1:0] tail_ptr [NUM_QUEUES];
   logic [CW-1:0] fill     [NUM_QUEUES];
   logic [3:0]    keep_bytes;
   queue_reply_type replies_due [$];

   function automatic logic [63:0] kept_mask(input logic [3:0] n_bytes);
      int n;
      n = (n_bytes > PAYLOAD_BYTES) ? PAYLOAD_BYTES : n_bytes;
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   function automatic logic [PW-1:0] ring_advance(input logic [PW-1:0] p);
      return (p == QUEUE_DEPTH - 1) ? '0 : p + PW'(1);
   endfunction

   function automatic queue_reply_type model_request(input logic [1:0] kind,
         input logic [QW-1:0] q, input logic [7:0] src, input logic [7:0] dst,
         input logic [63:0] payload);
      queue_reply_type r;
      r = '0;
      r.status = ST_OK;
      case (kind)
         REQ_ENQ: begin
            if (fill[q] >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               src_mem[q][tail_ptr[q]] = src;
               dst_mem[q][tail_ptr[q]] = dst;
               pay_mem[q][tail_ptr[q]] = payload & kept_mask(keep_bytes);
               tail_ptr[q] = ring_advance(tail_ptr[q]);
               fill[q] = fill[q] + CW'(1);
            end
         end
         REQ_DEQ: begin
            if (fill[q] == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.src = src_mem[q][head_ptr[q]];
               r.dst = dst_mem[q][head_ptr[q]];
               r.payload = pay_mem[q][head_ptr[q]];
               head_ptr[q] = ring_advance(head_ptr[q]);
               fill[q] = fill[q] - CW'(1);
            end
         end
         REQ_CLEAR: begin
            head_ptr[q] = '0;
            tail_ptr[q] = '0;
            fill[q] = '0;
         end
         default: begin
         end
      endcase
      r.occupancy = OCC_W'(fill[q]);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
         input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      queue_reply_type want;
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ptr[i] = '0;
            tail_ptr[i] = '0;
            fill[i] = '0;
         end
         keep_bytes = 4'd8;
         replies_due.delete();
         replies_pending = 0;
      end else begin
         if (csr_valid && csr_ready) keep_bytes = csr_data;
         if (rsp_strobe) begin
            if (replies_due.size() == 0) begin
               $error("response word with no request outstanding");
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("source_address_out", 64'(want.src),
                           64'(rsp_source_address_out));
               check_field("dest_address_out", 64'(want.dst),
                           64'(rsp_dest_address_out));
               check_field("payload_out", want.payload, rsp_payload_out);
               check_field("occupancy", 64'(want.occupancy), 64'(rsp_occupancy));
            end
         end
         if (start && !busy) begin
            want = model_request(req_type, req_queue_index, req_source_address,
                                 req_dest_address, req_payload_in);
            if (want.status == ST_FULL) full_drops++;
            if (want.status == ST_EMPTY) empty_reads++;
            replies_due.push_back(want);
         end
         replies_pending = replies_due.size();
      end
   end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the multi-queue packet FIFO testbench: clock, reset, request and csr stimulus.
// Depends on mqpf_pkg, the block and mqpf_checker, which does all the checking.
module testbench;
   import mqpf_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_SIZE;
   logic [3:0]  req_queue_index = '0;
   logic [7:0]  req_source_address = '0;
   logic [7:0]  req_dest_address = '0;
   logic [63:0] req_payload_in = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_source_address_out;
   logic [7:0]  rsp_dest_address_out;
   logic [63:0] rsp_payload_out;
   logic [4:0]  rsp_occupancy;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data = '0;

   int fail_count;
   int replies_pending;
   int full_drops;
   int empty_reads;
   int requests_sent = 0;
   int settings_used = 1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   multi_queue_packet_fifo uut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_type               (req_type),
      .req_queue_index        (req_queue_index),
      .req_source_address     (req_source_address),
      .req_dest_address       (req_dest_address),
      .req_payload_in         (req_payload_in),
      .rsp_strobe             (rsp_strobe),
      .rsp_status             (rsp_status),
      .rsp_source_address_out (rsp_source_address_out),
      .rsp_dest_address_out   (rsp_dest_address_out),
      .rsp_payload_out        (rsp_payload_out),
      .rsp_occupancy          (rsp_occupancy),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_data               (csr_data)
   );

   mqpf_checker scoreboard (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_type               (req_type),
      .req_queue_index        (req_queue_index),
      .req_source_address     (req_source_address),
      .req_dest_address       (req_dest_address),
      .req_payload_in         (req_payload_in),
      .rsp_strobe             (rsp_strobe),
      .rsp_status             (rsp_status),
      .rsp_source_address_out (rsp_source_address_out),
      .rsp_dest_address_out   (rsp_dest_address_out),
      .rsp_payload_out        (rsp_payload_out),
      .rsp_occupancy          (rsp_occupancy),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_data               (csr_data),
      .fail_count             (fail_count),
      .replies_pending        (replies_pending),
      .full_drops             (full_drops),
      .empty_reads            (empty_reads)
   );

   task automatic send_request(input logic [1:0] kind, input logic [3:0] q,
         input logic [7:0] src, input logic [7:0] dst, input logic [63:0] payload,
         input int gap);
      start <= 1'b1;
      req_type <= kind;
      req_queue_index <= q;
      req_source_address <= src;
      req_dest_address <= dst;
      req_payload_in <= payload;
      do @(posedge clock); while (busy);
      requests_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_request(input int enq_pct, input int idle_pct);
      int roll;
      logic [1:0] kind;
      logic [3:0] q;
      int gap;
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) kind = REQ_ENQ;
      else if (roll < 90) kind = REQ_DEQ;
      else if (roll < 96) kind = REQ_SIZE;
      else kind = REQ_CLEAR;
      q = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
      send_request(kind, q, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   {$urandom, $urandom}, gap);
   endtask

   // hold until every response word is back, then let the pipeline settle
   task automatic drain();
      int waited;
      waited = 0;
      start <= 1'b0;
      @(posedge clock);
      while (replies_pending != 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [3:0] phase_cfg [8];
      int enq_bias [8];
      int idle_bias [8];
      enq_bias = '{70, 35, 60, 30, 70, 45, 65, 40};
      idle_bias = '{0, 68, 15, 0, 68, 15, 0, 68};
      phase_cfg = '{4'd0, 4'd15, 4'd3, 4'd8, 4'd1, 4'd7, 4'($urandom_range(0, 15)), 4'd8};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_request(REQ_SIZE, 4'd0, 8'h00, 8'h00, 64'h0, 0);
      send_request(REQ_DEQ, 4'd0, 8'h00, 8'h00, 64'h0, 0);
      send_request(REQ_ENQ, 4'd15, 8'hFF, 8'hFF, '1, 0);
      send_request(REQ_ENQ, 4'd15, 8'h00, 8'h00, '0, 0);
      send_request(REQ_DEQ, 4'd15, 8'h00, 8'h00, 64'h0, 0);
      send_request(REQ_DEQ, 4'd15, 8'h00, 8'h00, 64'h0, 0);
      // fill queue 3 one past its depth
      for (int i = 0; i <= QUEUE_DEPTH; i++) begin
         send_request(REQ_ENQ, 4'd3, 8'(i), 8'(255 - i), {$urandom, $urandom}, 0);
      end
      send_request(REQ_CLEAR, 4'd3, 8'h00, 8'h00, 64'h0, 0);
      send_request(REQ_DEQ, 4'd3, 8'h00, 8'h00, 64'h0, 0);

      for (int p = 0; p < 8; p++) begin
         drain();
         write_csr(phase_cfg[p]);
         for (int i = 0; i < 120; i++) begin
            if (p == 2 && i == 60) drain();
            random_request(enq_bias[p], idle_bias[p]);
         end
      end

      drain();
      $display("Covered %0d requests across %0d payload-length settings and three gap rates;",
               requests_sent, settings_used);
      $display("%0d enqueues met a full queue, %0d dequeues met an empty one.",
               full_drops, empty_reads);
      if (fail_count == 0 && replies_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
